// ===== rtl/core/gspd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the gain-scheduled steering PD block.
// Holds the configuration record, register indexes and fixed arithmetic constants.
package gspd_pkg;

	typedef enum logic [2:0] {
		REG_DEVIATION_GAIN       = 3'd0,
		REG_RATE_GAIN            = 3'd1,
		REG_GYRO_GAIN            = 3'd2,
		REG_GYRO_DAMPING         = 3'd3,
		REG_DEVIATION_BOOST      = 3'd4,
		REG_GYRO_BOOST           = 3'd5,
		REG_BOOST_THRESHOLD      = 3'd6,
		REG_GYRO_BOOST_THRESHOLD = 3'd7
	} cfg_idx_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	typedef struct packed {
		logic        [11:0] deviation_gain;
		logic signed [12:0] rate_gain;
		logic        [9:0]  gyro_gain;
		logic signed [10:0] gyro_damping;
		logic signed [12:0] deviation_boost;
		logic signed [10:0] gyro_boost;
		logic        [6:0]  boost_threshold;
		logic        [6:0]  gyro_boost_threshold;
	} cfg_t;

	// Fixed excess offsets and gyro zoning limits on the deviation magnitude.
	localparam logic signed [8:0] DEV_EXCESS_BASE  = 9'sd50;
	localparam logic signed [8:0] GYRO_EXCESS_BASE = 9'sd75;
	localparam logic [7:0] ZONE_QUARTER_LIMIT = 8'd20;
	localparam logic [7:0] ZONE_HALF_LIMIT    = 8'd40;
	localparam logic [7:0] ZONE_FULL_LIMIT    = 8'd50;
	localparam logic signed [15:0] GYRO_CLAMP = 16'sd200;
	localparam logic [7:0] GYRO_CLAMP_MAG     = 8'd200;

	// Division by 50 and by 25 as a multiply by a rounded-up reciprocal.
	// Exact for the magnitudes that the boost products can reach.
	localparam logic [19:0] DIV50_MUL   = 20'd671089;
	localparam int          DIV50_SHIFT = 25;
	localparam logic [17:0] DIV25_MUL   = 18'd167773;
	localparam int          DIV25_SHIFT = 22;

	localparam logic signed [22:0] DRIVE_MAX = 23'sd4194303;
	localparam logic signed [22:0] DRIVE_MIN = -23'sd4194304;

endpackage

// ===== rtl/core/gspd_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the steering PD block.
// One carries sensor words in, the other carries drive words out; no dependencies.
interface gspd_in_if;
	logic               valid;
	logic               ready;
	logic signed [7:0]  deviation;
	logic signed [8:0]  deviation_rate;
	logic signed [15:0] gyro_rate;

	modport source (output valid, output deviation, output deviation_rate,
		output gyro_rate, input ready);
	modport sink (input valid, input deviation, input deviation_rate,
		input gyro_rate, output ready);
endinterface

interface gspd_out_if;
	logic               valid;
	logic               ready;
	logic signed [22:0] left_drive;
	logic signed [22:0] right_drive;

	modport source (output valid, output left_drive, output right_drive, input ready);
	modport sink (input valid, input left_drive, input right_drive, output ready);
endinterface

// ===== rtl/core/gain_scheduled_steering_pd.sv =====
`timescale 1ns / 1ps
// Top level of the gain-scheduled steering PD block: configuration registers and pipeline.
// Depends on gspd_pkg, the channel interfaces and gspd_datapath.
//
// Each input word (deviation, deviation rate, gyro rate) yields one output word with the
// left and right steering drives. The block takes one word per clock cycle unless the
// output stalls, and each word passes through six register stages: magnitude and
// zoning, boost products, reciprocal divides, gain scheduling, term products and the
// saturating sum. A full output register does not stop earlier stages from filling.
// The eight gain and threshold registers are written through the plain write port and
// come out of reset at their documented defaults; write them only while no word is in flight.
module gain_scheduled_steering_pd (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [gspd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gspd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	gspd_in_if.sink                          samples,
	gspd_out_if.source                       drives
);
	import gspd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deviation_gain       <= 12'd700;
			cfg_q.rate_gain            <= -13'sd1000;
			cfg_q.gyro_gain            <= 10'd100;
			cfg_q.gyro_damping         <= 11'sd0;
			cfg_q.deviation_boost      <= 13'sd0;
			cfg_q.gyro_boost           <= 11'sd0;
			cfg_q.boost_threshold      <= 7'd50;
			cfg_q.gyro_boost_threshold <= 7'd75;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_DEVIATION_GAIN: begin
					cfg_q.deviation_gain <= cfg_wdata[11:0];
				end
				REG_RATE_GAIN: begin
					cfg_q.rate_gain <= $signed(cfg_wdata[12:0]);
				end
				REG_GYRO_GAIN: begin
					cfg_q.gyro_gain <= cfg_wdata[9:0];
				end
				REG_GYRO_DAMPING: begin
					cfg_q.gyro_damping <= $signed(cfg_wdata[10:0]);
				end
				REG_DEVIATION_BOOST: begin
					cfg_q.deviation_boost <= $signed(cfg_wdata[12:0]);
				end
				REG_GYRO_BOOST: begin
					cfg_q.gyro_boost <= $signed(cfg_wdata[10:0]);
				end
				REG_BOOST_THRESHOLD: begin
					cfg_q.boost_threshold <= cfg_wdata[6:0];
				end
				REG_GYRO_BOOST_THRESHOLD: begin
					cfg_q.gyro_boost_threshold <= cfg_wdata[6:0];
				end
				default: begin
				end
			endcase
		end
	end

	gspd_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.samples (samples),
		.drives  (drives)
	);

endmodule

// ===== rtl/core/gspd_datapath.sv =====
`timescale 1ns / 1ps
// Six-stage pipeline of the gain-scheduled PD law, with per-stage valid bits.
// Depends on gspd_pkg and the gspd_in_if / gspd_out_if interfaces.
module gspd_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  gspd_pkg::cfg_t cfg,
	gspd_in_if.sink       samples,
	gspd_out_if.source    drives
);
	import gspd_pkg::*;

	function automatic logic signed [22:0] saturate(input logic signed [24:0] v);
		logic signed [24:0] hi;
		logic signed [24:0] lo;
		hi = 25'(DRIVE_MAX);
		lo = 25'(DRIVE_MIN);
		if (v > hi) begin
			return DRIVE_MAX;
		end else if (v < lo) begin
			return DRIVE_MIN;
		end
		return v[22:0];
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	assign rdy6 = !v_s6 || drives.ready;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign samples.ready = rdy1;
	assign drives.valid  = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= samples.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	// Stage 1: magnitude, zoning, gyro clamp and the rate product.
	logic        [7:0]  mag_c;
	logic signed [7:0]  exc50_c, exc75_c;
	logic        [9:0]  zone_c;
	logic        [7:0]  gabs_c;
	logic signed [8:0]  gterm_c;
	logic signed [21:0] rate_prod_c;
	logic               dev_pos_c;

	always_comb begin
		mag_c = samples.deviation[7] ? 8'(-samples.deviation) : 8'(samples.deviation);
		exc50_c = 8'($signed({1'b0, mag_c}) - DEV_EXCESS_BASE);
		exc75_c = 8'($signed({1'b0, mag_c}) - GYRO_EXCESS_BASE);
		if (mag_c < ZONE_QUARTER_LIMIT) begin
			zone_c = '0;
		end else if (mag_c < ZONE_HALF_LIMIT) begin
			zone_c = cfg.gyro_gain >> 2;
		end else if (mag_c < ZONE_FULL_LIMIT) begin
			zone_c = cfg.gyro_gain >> 1;
		end else begin
			zone_c = cfg.gyro_gain;
		end
		if (samples.gyro_rate > GYRO_CLAMP || samples.gyro_rate < -GYRO_CLAMP) begin
			gabs_c = GYRO_CLAMP_MAG;
		end else begin
			gabs_c = samples.gyro_rate[15] ? 8'(-samples.gyro_rate) : 8'(samples.gyro_rate);
		end
		dev_pos_c = !samples.deviation[7] && (samples.deviation != 8'sd0);
		gterm_c = dev_pos_c ? -$signed({1'b0, gabs_c}) : $signed({1'b0, gabs_c});
		rate_prod_c = 22'(cfg.rate_gain) * 22'(samples.deviation_rate);
	end

	logic signed [7:0]  dev_s1, exc50_s1, exc75_s1;
	logic               den_s1, gen_s1;
	logic        [9:0]  zone_s1;
	logic signed [8:0]  gterm_s1;
	logic signed [21:0] rate_s1;

	always_ff @(posedge clk) begin
		if (rdy1 && samples.valid) begin
			dev_s1   <= samples.deviation;
			exc50_s1 <= exc50_c;
			exc75_s1 <= exc75_c;
			den_s1   <= mag_c > {1'b0, cfg.boost_threshold};
			gen_s1   <= mag_c > {1'b0, cfg.gyro_boost_threshold};
			zone_s1  <= zone_c;
			gterm_s1 <= gterm_c;
			rate_s1  <= rate_prod_c;
		end
	end

	// Stage 2: boost products, kept as sign and magnitude.
	logic signed [20:0] pd_c;
	logic signed [18:0] pg_c;

	assign pd_c = 21'(cfg.deviation_boost) * 21'(exc50_s1);
	assign pg_c = 19'(cfg.gyro_boost) * 19'(exc75_s1);

	logic signed [7:0]  dev_s2;
	logic        [19:0] pd_mag_s2;
	logic        [17:0] pg_mag_s2;
	logic               pd_neg_s2, pg_neg_s2, den_s2, gen_s2;
	logic        [9:0]  zone_s2;
	logic signed [8:0]  gterm_s2;
	logic signed [21:0] rate_s2;

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			dev_s2    <= dev_s1;
			pd_mag_s2 <= pd_c[20] ? 20'(-pd_c) : 20'(pd_c);
			pg_mag_s2 <= pg_c[18] ? 18'(-pg_c) : 18'(pg_c);
			pd_neg_s2 <= pd_c[20];
			pg_neg_s2 <= pg_c[18];
			den_s2    <= den_s1;
			gen_s2    <= gen_s1;
			zone_s2   <= zone_s1;
			gterm_s2  <= gterm_s1;
			rate_s2   <= rate_s1;
		end
	end

	// Stage 3: reciprocal multiplies give the truncated quotients.
	logic [39:0] qd_prod_c;
	logic [35:0] qg_prod_c;

	assign qd_prod_c = 40'(pd_mag_s2) * 40'(DIV50_MUL);
	assign qg_prod_c = 36'(pg_mag_s2) * 36'(DIV25_MUL);

	logic signed [7:0]  dev_s3;
	logic        [12:0] qd_s3;
	logic        [11:0] qg_s3;
	logic               pd_neg_s3, pg_neg_s3, den_s3, gen_s3;
	logic        [9:0]  zone_s3;
	logic signed [8:0]  gterm_s3;
	logic signed [21:0] rate_s3;

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			dev_s3    <= dev_s2;
			qd_s3     <= qd_prod_c[DIV50_SHIFT +: 13];
			qg_s3     <= qg_prod_c[DIV25_SHIFT +: 12];
			pd_neg_s3 <= pd_neg_s2;
			pg_neg_s3 <= pg_neg_s2;
			den_s3    <= den_s2;
			gen_s3    <= gen_s2;
			zone_s3   <= zone_s2;
			gterm_s3  <= gterm_s2;
			rate_s3   <= rate_s2;
		end
	end

	// Stage 4: scheduled deviation gain and gyro coefficient.
	logic signed [13:0] dboost_c;
	logic signed [12:0] gboost_c;
	logic signed [14:0] dgain_c;
	logic signed [13:0] gcoef_c;

	always_comb begin
		if (!den_s3) begin
			dboost_c = '0;
		end else if (pd_neg_s3) begin
			dboost_c = -$signed({1'b0, qd_s3});
		end else begin
			dboost_c = $signed({1'b0, qd_s3});
		end
		if (!gen_s3) begin
			gboost_c = '0;
		end else if (pg_neg_s3) begin
			gboost_c = -$signed({1'b0, qg_s3});
		end else begin
			gboost_c = $signed({1'b0, qg_s3});
		end
		dgain_c = $signed({3'b000, cfg.deviation_gain}) + 15'(dboost_c);
		gcoef_c = $signed({4'b0000, zone_s3}) + 14'(gboost_c) - 14'(cfg.gyro_damping);
	end

	logic signed [7:0]  dev_s4;
	logic signed [14:0] dgain_s4;
	logic signed [13:0] gcoef_s4;
	logic signed [8:0]  gterm_s4;
	logic signed [21:0] rate_s4;

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			dev_s4   <= dev_s3;
			dgain_s4 <= dgain_c;
			gcoef_s4 <= gcoef_c;
			gterm_s4 <= gterm_s3;
			rate_s4  <= rate_s3;
		end
	end

	// Stage 5: deviation and gyro terms.
	logic signed [22:0] dterm_c, gprod_c;

	assign dterm_c = -(23'(dgain_s4) * 23'(dev_s4));
	assign gprod_c = 23'(gcoef_s4) * 23'(gterm_s4);

	logic signed [22:0] dterm_s5, gprod_s5;
	logic signed [21:0] rate_s5;

	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			dterm_s5 <= dterm_c;
			gprod_s5 <= gprod_c;
			rate_s5  <= rate_s4;
		end
	end

	// Stage 6: sum, saturate, output register.
	logic signed [24:0] sum_c, neg_c;

	assign sum_c = 25'(dterm_s5) - 25'(rate_s5) + 25'(gprod_s5);
	assign neg_c = -sum_c;

	logic signed [22:0] left_s6, right_s6;

	always_ff @(posedge clk) begin
		if (rdy6 && v_s5) begin
			left_s6  <= saturate(sum_c);
			right_s6 <= saturate(neg_c);
		end
	end

	assign drives.left_drive  = left_s6;
	assign drives.right_drive = right_s6;

endmodule
